// File: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset disable
`define SLDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication
`define SLDF_IMPLY(label, ante, cons, msg) \
  `SLDF_ASSERT(label, (ante) |-> (cons), msg)

`endif

// File: rtl/sldf_pkg.sv
package sldf_pkg;

  localparam int FrameBytes = 18;
  localparam int NumLanes   = 9;
  localparam int NumDigits  = 5;

  localparam logic [4:0] LastIndex = 5'(FrameBytes - 1);

  // digit lanes
  localparam int LaneMile  = 0;
  localparam int LaneVolt  = 1;
  localparam int LaneFile  = 2;
  localparam int LaneFreq  = 3;
  localparam int LaneMin   = 4;
  localparam int LaneSec   = 5;
  localparam int LaneVol   = 6;
  localparam int LaneChan  = 7;
  localparam int LaneSpeed = 8;

  // flag bit positions
  localparam int FlagLeft       = 0;
  localparam int FlagRight      = 1;
  localparam int FlagLight      = 2;
  localparam int FlagShowVol    = 3;
  localparam int FlagShowNum    = 4;
  localparam int FlagPaused     = 5;
  localparam int FlagPlayFlash  = 6;
  localparam int FlagMute       = 7;
  localparam int FlagMileFlash  = 8;
  localparam int FlagSpeedFlash = 9;

  // fixed glyphs
  localparam logic [7:0] GlyphP    = 8'hCE;
  localparam logic [7:0] GlyphA    = 8'hEE;
  localparam logic [7:0] GlyphU    = 8'h7A;
  localparam logic [7:0] GlyphS    = 8'hBC;
  localparam logic [7:0] GlyphC    = 8'h9A;
  localparam logic [7:0] GlyphH    = 8'h6E;
  localparam logic [7:0] GlyphF    = 8'h8E;
  localparam logic [7:0] GlyphO    = 8'hFA;
  localparam logic [7:0] MarkBit   = 8'h08;
  localparam logic [7:0] DotBit    = 8'h01;
  localparam logic [7:0] KeepDot   = 8'h01;

  typedef enum logic [1:0] {
    MediaUsb = 2'd0,
    MediaSd  = 2'd1,
    MediaFm  = 2'd2,
    MediaOff = 2'd3
  } media_e;

  typedef struct packed {
    logic [9:0] flags;
    logic [3:0] battery_level;
    media_e     media;
  } meta_t;

  typedef struct packed {
    meta_t                                  meta;
    logic [NumLanes-1:0][16:0]              val;
    logic [NumLanes-1:0][NumDigits-1:0][3:0] dig;
  } work_t;

  typedef logic [FrameBytes-1:0][7:0] frame_t;

  function automatic logic [16:0] div10(input logic [16:0] x);
    logic [32:0] p;
    p = 33'(x) * 33'd52429;
    return {3'b000, p[32:19]};
  endfunction

  function automatic logic [3:0] rem10(input logic [16:0] x, input logic [16:0] q);
    logic [16:0] m10;
    logic [16:0] d;
    m10 = {q[13:0], 3'b000} + {q[15:0], 1'b0};
    d = x - m10;
    return d[3:0];
  endfunction

  function automatic logic [7:0] div60(input logic [12:0] s);
    logic [27:0] p;
    p = 28'(s) * 28'd17477;
    return p[27:20];
  endfunction

  function automatic logic [5:0] rem60(input logic [12:0] s, input logic [7:0] q);
    logic [13:0] m60;
    logic [13:0] d;
    m60 = {q, 6'b000000} - {4'b0000, q, 2'b00};
    d = {1'b0, s} - m60;
    return d[5:0];
  endfunction

  function automatic logic [7:0] media_font(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0: g = 8'hFA;
      4'd1: g = 8'h60;
      4'd2: g = 8'hD6;
      4'd3: g = 8'hF4;
      4'd4: g = 8'h6C;
      4'd5: g = 8'hBC;
      4'd6: g = 8'hBE;
      4'd7: g = 8'hE0;
      4'd8: g = 8'hFE;
      4'd9: g = 8'hFC;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] main_font(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0: g = 8'hF5;
      4'd1: g = 8'h60;
      4'd2: g = 8'hD3;
      4'd3: g = 8'hF2;
      4'd4: g = 8'h66;
      4'd5: g = 8'hB6;
      4'd6: g = 8'hB7;
      4'd7: g = 8'hE0;
      4'd8: g = 8'hF7;
      4'd9: g = 8'hF6;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

// File: rtl/sldf_if.sv
interface sldf_snap_if;
  logic        valid;
  logic        ready;
  logic [9:0]  flags;
  logic [3:0]  battery_level;
  logic [9:0]  voltage;
  logic [1:0]  media;
  logic [6:0]  volume_level;
  logic [13:0] file_number;
  logic [12:0] play_seconds;
  logic [6:0]  fm_channel;
  logic [13:0] fm_freq;
  logic [16:0] mileage;
  logic [6:0]  speed;

  modport source (
    output valid, flags, battery_level, voltage, media, volume_level, file_number,
           play_seconds, fm_channel, fm_freq, mileage, speed,
    input  ready
  );
  modport sink (
    input  valid, flags, battery_level, voltage, media, volume_level, file_number,
           play_seconds, fm_channel, fm_freq, mileage, speed,
    output ready
  );
endinterface

interface sldf_byte_if;
  logic       valid;
  logic       ready;
  logic [4:0] byte_index;
  logic [7:0] segment_byte;
  logic       last_byte;

  modport source (
    output valid, byte_index, segment_byte, last_byte,
    input  ready
  );
  modport sink (
    input  valid, byte_index, segment_byte, last_byte,
    output ready
  );
endinterface

// File: rtl/sldf_intake.sv
module sldf_intake (
  input  logic               clk_i,
  input  logic               rst_ni,
  sldf_snap_if.sink          snap_i,
  output logic               valid_o,
  input  logic               ready_i,
  output sldf_pkg::work_t    work_o
);

  logic            valid_q;
  logic            load;
  logic [7:0]      mins;
  logic [5:0]      secs_rem;
  logic [6:0]      spd_sat;
  sldf_pkg::work_t work_d;
  sldf_pkg::work_t work_q;

  assign snap_i.ready = !valid_q || ready_i;
  assign load         = snap_i.valid && snap_i.ready;

  always_comb begin
    mins     = sldf_pkg::div60(snap_i.play_seconds);
    secs_rem = sldf_pkg::rem60(snap_i.play_seconds, mins);
    spd_sat  = (snap_i.speed > 7'd99) ? 7'd99 : snap_i.speed;

    work_d                    = '0;
    work_d.meta.flags         = snap_i.flags;
    work_d.meta.battery_level = snap_i.battery_level;
    work_d.meta.media         = sldf_pkg::media_e'(snap_i.media);
    work_d.val[sldf_pkg::LaneMile]  = snap_i.mileage;
    work_d.val[sldf_pkg::LaneVolt]  = 17'(snap_i.voltage);
    work_d.val[sldf_pkg::LaneFile]  = 17'(snap_i.file_number);
    work_d.val[sldf_pkg::LaneFreq]  = 17'(snap_i.fm_freq);
    work_d.val[sldf_pkg::LaneMin]   = 17'(mins);
    work_d.val[sldf_pkg::LaneSec]   = 17'(secs_rem);
    work_d.val[sldf_pkg::LaneVol]   = 17'(snap_i.volume_level);
    work_d.val[sldf_pkg::LaneChan]  = 17'(snap_i.fm_channel);
    work_d.val[sldf_pkg::LaneSpeed] = 17'(spd_sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

// File: rtl/sldf_digit_stage.sv
module sldf_digit_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  sldf_pkg::work_t work_i,
  output logic            valid_o,
  input  logic            ready_i,
  output sldf_pkg::work_t work_o
);

  logic            valid_q;
  logic            load;
  logic [16:0]     quot;
  sldf_pkg::work_t work_d;
  sldf_pkg::work_t work_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // one decimal digit off every lane, newest digit enters at the top
  always_comb begin
    work_d      = work_i;
    quot        = '0;
    for (int l = 0; l < sldf_pkg::NumLanes; l++) begin
      quot          = sldf_pkg::div10(work_i.val[l]);
      work_d.val[l] = quot;
      work_d.dig[l] = {sldf_pkg::rem10(work_i.val[l], quot),
                       work_i.dig[l][sldf_pkg::NumDigits-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

// File: rtl/sldf_frame_build.sv
module sldf_frame_build #(
  parameter int BLINK_PERIOD = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  sldf_pkg::work_t  work_i,
  output sldf_pkg::frame_t frame_o
);

  localparam logic [3:0] PhaseLast = 4'(BLINK_PERIOD - 1);
  localparam logic [3:0] BlinkOn   = 4'(BLINK_PERIOD / 2);

  logic [3:0]       blink_q, blink_d;
  logic [3:0]       left_q, left_d;
  logic [3:0]       right_q, right_d;
  logic             blank;
  logic [9:0]       fl;
  sldf_pkg::frame_t b;

  function automatic logic [3:0] step_phase(input logic [3:0] p);
    return (p == PhaseLast) ? 4'd0 : p + 4'd1;
  endfunction

  always_comb begin
    fl      = work_i.meta.flags;
    blink_d = step_phase(blink_q);
    blank   = blink_d < BlinkOn;
    b       = '0;

    // turn indicators and light
    left_d = fl[sldf_pkg::FlagLeft] ? step_phase(left_q) : 4'd0;
    if (fl[sldf_pkg::FlagLeft] && (left_d < BlinkOn)) begin
      b[14] = b[14] | sldf_pkg::MarkBit;
    end
    right_d = fl[sldf_pkg::FlagRight] ? step_phase(right_q) : 4'd0;
    if (fl[sldf_pkg::FlagRight] && (right_d < BlinkOn)) begin
      b[15] = b[15] | sldf_pkg::MarkBit;
    end
    if (fl[sldf_pkg::FlagLight]) begin
      b[13] = b[13] | sldf_pkg::MarkBit;
    end

    // battery bar
    b[15] = b[15] | 8'h80;
    b[8]  = b[8] | 8'h10;
    unique case (work_i.meta.battery_level)
      4'd0: begin
        if (blank) begin
          b[8] = b[8] & 8'hEF;
        end
      end
      4'd1: b[8] = b[8] | 8'h30;
      4'd2: b[8] = b[8] | 8'h70;
      4'd3: b[8] = b[8] | 8'hF0;
      4'd4: b[8] = b[8] | 8'hF8;
      4'd5: b[8] = b[8] | 8'hFC;
      4'd6: b[8] = b[8] | 8'hFE;
      4'd7: b[8] = b[8] | 8'hFF;
      4'd8: begin
        b[8]  = b[8] | 8'hFF;
        b[15] = b[15] | 8'h10;
      end
      default: begin
        b[8]  = b[8] | 8'hFF;
        b[15] = b[15] | 8'h30;
      end
    endcase

    // voltage
    b[7] = b[7] | sldf_pkg::main_font(work_i.dig[sldf_pkg::LaneVolt][2]);
    b[6] = b[6] | sldf_pkg::main_font(work_i.dig[sldf_pkg::LaneVolt][1]);
    b[4] = b[4] | (sldf_pkg::main_font(work_i.dig[sldf_pkg::LaneVolt][0]) & 8'hF0);
    b[3] = b[3] | (sldf_pkg::main_font(work_i.dig[sldf_pkg::LaneVolt][0]) & 8'h0F);
    b[7] = b[7] | sldf_pkg::MarkBit;
    b[3] = b[3] | sldf_pkg::MarkBit;

    // media area
    if (work_i.meta.media != sldf_pkg::MediaOff) begin
      b[15] = b[15] | 8'h04;
    end
    if (work_i.meta.media == sldf_pkg::MediaUsb) begin
      b[15] = b[15] | 8'h01;
    end else if (work_i.meta.media == sldf_pkg::MediaFm) begin
      b[1] = b[1] | sldf_pkg::MarkBit;
    end

    if (fl[sldf_pkg::FlagShowVol]) begin
      b[11] = b[11] | sldf_pkg::GlyphU;
      b[17] = b[17] | sldf_pkg::media_font(work_i.dig[sldf_pkg::LaneVol][1]);
      b[16] = b[16] | sldf_pkg::media_font(work_i.dig[sldf_pkg::LaneVol][0]);
    end else begin
      unique case (work_i.meta.media)
        sldf_pkg::MediaUsb: begin
          if (fl[sldf_pkg::FlagShowNum]) begin
            b[12] = b[12] | sldf_pkg::media_font(work_i.dig[sldf_pkg::LaneFile][3]);
            b[11] = b[11] | sldf_pkg::media_font(work_i.dig[sldf_pkg::LaneFile][2]);
            b[17] = b[17] | sldf_pkg::media_font(work_i.dig[sldf_pkg::LaneFile][1]);
            b[16] = b[16] | sldf_pkg::media_font(work_i.dig[sldf_pkg::LaneFile][0]);
          end else begin
            b[12] = b[12] | sldf_pkg::media_font(work_i.dig[sldf_pkg::LaneMin][1]);
            b[11] = b[11] | sldf_pkg::media_font(work_i.dig[sldf_pkg::LaneMin][0]);
            b[17] = b[17] | sldf_pkg::media_font(work_i.dig[sldf_pkg::LaneSec][1]);
            b[16] = b[16] | sldf_pkg::media_font(work_i.dig[sldf_pkg::LaneSec][0]);
            b[17] = b[17] | sldf_pkg::DotBit;
          end
          if (fl[sldf_pkg::FlagPaused]) begin
            b[12] = sldf_pkg::GlyphP;
            b[11] = sldf_pkg::GlyphA;
            b[17] = sldf_pkg::GlyphU;
            b[16] = sldf_pkg::GlyphS;
          end
        end
        sldf_pkg::MediaFm: begin
          if (fl[sldf_pkg::FlagShowNum]) begin
            b[12] = b[12] | sldf_pkg::GlyphC;
            b[11] = b[11] | sldf_pkg::GlyphH;
            b[17] = b[17] | sldf_pkg::media_font(work_i.dig[sldf_pkg::LaneChan][1]);
            b[16] = b[16] | sldf_pkg::media_font(work_i.dig[sldf_pkg::LaneChan][0]);
          end else begin
            b[16] = b[16] | sldf_pkg::DotBit;
            b[12] = b[12] | sldf_pkg::media_font(work_i.dig[sldf_pkg::LaneFreq][3]);
            b[11] = b[11] | sldf_pkg::media_font(work_i.dig[sldf_pkg::LaneFreq][2]);
            b[17] = b[17] | sldf_pkg::media_font(work_i.dig[sldf_pkg::LaneFreq][1]);
            b[16] = b[16] | sldf_pkg::media_font(work_i.dig[sldf_pkg::LaneFreq][0]);
          end
        end
        sldf_pkg::MediaOff: begin
          b[11] = b[11] | sldf_pkg::GlyphO;
          b[17] = b[17] | sldf_pkg::GlyphF;
          b[16] = b[16] | sldf_pkg::GlyphF;
        end
        default: begin
        end
      endcase
    end
    if ((fl[sldf_pkg::FlagPlayFlash] || fl[sldf_pkg::FlagMute]) && blank) begin
      b[12] = b[12] & sldf_pkg::KeepDot;
      b[11] = b[11] & sldf_pkg::KeepDot;
      b[17] = 8'h00;
      b[16] = b[16] & sldf_pkg::KeepDot;
    end

    // mileage
    b[2] = b[2] | sldf_pkg::MarkBit;
    b[5] = b[5] | (sldf_pkg::main_font(work_i.dig[sldf_pkg::LaneMile][4]) & 8'hF0);
    b[4] = b[4] | (sldf_pkg::main_font(work_i.dig[sldf_pkg::LaneMile][4]) & 8'h0F);
    b[0] = b[0] | (sldf_pkg::main_font(work_i.dig[sldf_pkg::LaneMile][3]) & 8'hF0);
    b[5] = b[5] | (sldf_pkg::main_font(work_i.dig[sldf_pkg::LaneMile][3]) & 8'h0F);
    b[1] = b[1] | (sldf_pkg::main_font(work_i.dig[sldf_pkg::LaneMile][2]) & 8'hF0);
    b[0] = b[0] | (sldf_pkg::main_font(work_i.dig[sldf_pkg::LaneMile][2]) & 8'h0F);
    b[2] = b[2] | (sldf_pkg::main_font(work_i.dig[sldf_pkg::LaneMile][1]) & 8'hF0);
    b[1] = b[1] | (sldf_pkg::main_font(work_i.dig[sldf_pkg::LaneMile][1]) & 8'h0F);
    b[3] = b[3] | (sldf_pkg::main_font(work_i.dig[sldf_pkg::LaneMile][0]) & 8'hF0);
    b[2] = b[2] | (sldf_pkg::main_font(work_i.dig[sldf_pkg::LaneMile][0]) & 8'h0F);
    if (fl[sldf_pkg::FlagMileFlash] && blank) begin
      b[4] = b[4] & sldf_pkg::KeepDot;
      b[5] = b[5] & sldf_pkg::KeepDot;
      b[0] = b[0] & sldf_pkg::KeepDot;
      b[1] = b[1] & sldf_pkg::KeepDot;
      b[2] = b[2] & sldf_pkg::KeepDot;
    end

    // speed
    b[0]  = b[0] | sldf_pkg::MarkBit;
    b[14] = b[14] | sldf_pkg::main_font(work_i.dig[sldf_pkg::LaneSpeed][1]);
    b[13] = b[13] | sldf_pkg::main_font(work_i.dig[sldf_pkg::LaneSpeed][0]);
    if (fl[sldf_pkg::FlagSpeedFlash] && blank) begin
      b[14] = b[14] & sldf_pkg::KeepDot;
      b[13] = b[13] & sldf_pkg::KeepDot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_q <= 4'd0;
      left_q  <= 4'd0;
      right_q <= 4'd0;
    end else if (advance_i) begin
      blink_q <= blink_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign frame_o = b;

endmodule

// File: rtl/sldf_emit.sv
module sldf_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  sldf_pkg::frame_t frame_i,
  sldf_byte_if.source      byte_o
);

  logic             valid_q, valid_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             last;
  logic             load;
  sldf_pkg::frame_t frame_q;

  assign last    = cnt_q == sldf_pkg::LastIndex;
  assign ready_o = !valid_q || (byte_o.ready && last);
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    if (valid_q && byte_o.ready) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 5'd1;
      end
    end
    if (load) begin
      valid_d = 1'b1;
      cnt_d   = 5'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 5'd0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= frame_i;
    end
  end

  assign byte_o.valid        = valid_q;
  assign byte_o.byte_index   = cnt_q;
  assign byte_o.segment_byte = frame_q[cnt_q];
  assign byte_o.last_byte    = last;

endmodule

// File: rtl/segment_lcd_dashboard_formatter.sv
// segment lcd dashboard formatter
// snap_i takes one dashboard status snapshot per request (valid/ready); byte_o
// returns its 18-byte display frame, one byte per request, byte_index 0 to 17
// in ascending order with last_byte set on byte 17.
// a snapshot, once taken, passes one intake register, five digit stages that
// each peel one decimal digit off every field, then the frame register, from
// which the first byte of its frame is offered when the output is free.
// the snapshot rate is set by the single byte-wide output, one byte at a time;
// bytes of a frame leave back to back while the receiver keeps ready high.
// up to six further snapshots wait in the pipeline while a frame drains, so
// snap_i stays ready until the stages are full.
// the blink counters step once per frame, in snapshot order, as it enters the
// frame register; BLINK_PERIOD sets their modulus.
// when the receiver stalls, the current byte holds on byte_o and the pipeline
// fills up before snap_i drops ready.
// reset clears all stage valids, the byte counter and the three blink counters
// to zero; no frame is pending afterwards.
module segment_lcd_dashboard_formatter #(
  parameter int BLINK_PERIOD = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sldf_snap_if.sink    snap_i,
  sldf_byte_if.source  byte_o
);

  logic [sldf_pkg::NumDigits:0] stg_valid;
  logic [sldf_pkg::NumDigits:0] stg_ready;
  sldf_pkg::work_t              stg_work [sldf_pkg::NumDigits+1];
  sldf_pkg::frame_t             frame;
  logic                         emit_ready;

  sldf_intake u_intake (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .snap_i  (snap_i),
    .valid_o (stg_valid[0]),
    .ready_i (stg_ready[0]),
    .work_o  (stg_work[0])
  );

  for (genvar k = 0; k < sldf_pkg::NumDigits; k++) begin : g_digit
    sldf_digit_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[k]),
      .ready_o (stg_ready[k]),
      .work_i  (stg_work[k]),
      .valid_o (stg_valid[k+1]),
      .ready_i (stg_ready[k+1]),
      .work_o  (stg_work[k+1])
    );
  end

  assign stg_ready[sldf_pkg::NumDigits] = emit_ready;

  sldf_frame_build #(
    .BLINK_PERIOD (BLINK_PERIOD)
  ) u_frame_build (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (stg_valid[sldf_pkg::NumDigits] && emit_ready),
    .work_i    (stg_work[sldf_pkg::NumDigits]),
    .frame_o   (frame)
  );

  sldf_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stg_valid[sldf_pkg::NumDigits]),
    .ready_o (emit_ready),
    .frame_i (frame),
    .byte_o  (byte_o)
  );

endmodule

// File: rtl/sldf_checker.sv
`include "assert_macros.svh"

module sldf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [4:0] out_index_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  `SLDF_IMPLY(a_last_flag, out_valid_i, (out_last_i == (out_index_i == sldf_pkg::LastIndex)), "last_byte does not match final index")
  `SLDF_IMPLY(a_index_range, out_valid_i, (out_index_i <= sldf_pkg::LastIndex), "byte index beyond frame")
  `SLDF_ASSERT(a_index_step, (out_valid_i && out_ready_i && !out_last_i) |=> (out_valid_i && (out_index_i == $past(out_index_i) + 5'd1)), "frame byte missing or out of order")
  `SLDF_ASSERT(a_frame_start, (out_valid_i && out_ready_i && out_last_i) |=> (!out_valid_i || (out_index_i == 5'd0)), "new frame does not start at byte zero")
  `SLDF_ASSERT(a_stall_hold, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_index_i) && $stable(out_byte_i)), "stalled byte changed")

endmodule

bind segment_lcd_dashboard_formatter sldf_checker u_sldf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (byte_o.valid),
  .out_ready_i (byte_o.ready),
  .out_index_i (byte_o.byte_index),
  .out_byte_i  (byte_o.segment_byte),
  .out_last_i  (byte_o.last_byte)
);
